[hdl/fbrle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrle_pkg
// Shared types, item kinds and helpers for the fill and glyph blit engine.
// ----------------------------------------------------------------------------
package fbrle_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 240;

  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_FILL  = 3'd1;
  localparam logic [2:0] KIND_GSTART = 3'd2;
  localparam logic [2:0] KIND_GBYTE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [7:0] RUN_FLAG   = 8'b10000000;
  localparam logic [5:0] GRAY_MASK  = 6'b111111;
  localparam logic [5:0] TINT_MASK  = 6'b111110;
  localparam logic [2:0] GREEN_LOW  = 3'b111;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;   // capture input item
    logic rect_init;   // set up clipped bounds and cursor
    logic rect_step;   // write one pixel, advance
    logic gly_start;   // load glyph state
    logic gly_latch;   // latch pending gray, set awaiting
    logic gly_lit;     // prepare literal pixel
    logic gly_run;     // prepare run of pending gray
    logic gly_step;    // write one glyph pixel, advance
    logic rd_issue;    // issue read
    logic rd_take;     // capture read data into output register
  } fbrle_cmd_t;

  typedef struct packed {
    logic rect_last;
    logic rect_empty;
    logic gly_last;
    logic awaiting;
    logic run_flag;
  } fbrle_sts_t;

  function automatic logic [15:0] pack_shade(input logic [5:0] gray, input logic [5:0] tr,
                                             input logic [5:0] tg, input logic [5:0] tb);
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
    r = gray * tr;
    g = gray * tg;
    b = gray * tb;
    return {g[8:6], b[11:7], r[11:7], g[11:9]};
  endfunction

endpackage

[hdl/fbrle_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrle_ctrl
// Sequencer: decodes an item kind and steps the datapath through its work.
// ----------------------------------------------------------------------------
module fbrle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            kind,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  fbrle_pkg::fbrle_sts_t sts,
  output fbrle_pkg::fbrle_cmd_t cmd,
  output logic                  out_set
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RECT = 3'd2;
  localparam logic [2:0] S_GLY  = 3'd3;
  localparam logic [2:0] S_RD1  = 3'd4;
  localparam logic [2:0] S_RD2  = 3'd5;
  localparam logic [2:0] S_RINI = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] kind_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (in_valid && in_ready) begin
      kind_q <= kind;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    out_set = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        priority case (kind_q)
          fbrle_pkg::KIND_CLEAR, fbrle_pkg::KIND_FILL: begin
            cmd.rect_init = 1'b1;
            state_next = S_RINI;
          end
          fbrle_pkg::KIND_GSTART: begin
            cmd.gly_start = 1'b1;
            state_next = S_IDLE;
          end
          fbrle_pkg::KIND_GBYTE: begin
            if (sts.awaiting) begin
              cmd.gly_run = 1'b1;
              state_next = S_GLY;
            end else if (sts.run_flag) begin
              cmd.gly_latch = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.gly_lit = 1'b1;
              state_next = S_GLY;
            end
          end
          fbrle_pkg::KIND_READ: begin
            if (!out_valid || out_ready) begin
              cmd.rd_issue = 1'b1;
              state_next = S_RD1;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RINI: begin
        state_next = sts.rect_empty ? S_IDLE : S_RECT;
      end
      S_RECT: begin
        cmd.rect_step = 1'b1;
        if (sts.rect_last) state_next = S_IDLE;
      end
      S_GLY: begin
        cmd.gly_step = 1'b1;
        if (sts.gly_last) state_next = S_IDLE;
      end
      S_RD1: state_next = S_RD2;
      S_RD2: begin
        cmd.rd_take = 1'b1;
        out_set = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/fbrle_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrle_dpath
// Frame store, clipping, glyph cursor, shading and read path.
// ----------------------------------------------------------------------------
module fbrle_dpath #(
  parameter int SCREEN_WIDTH  = fbrle_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = fbrle_pkg::SCREEN_HEIGHT
) (
  input  logic                  clk,
  input  logic [2:0]            kind,
  input  logic signed [10:0]    x_pos,
  input  logic signed [10:0]    y_pos,
  input  logic [9:0]            width_px,
  input  logic [9:0]            height_px,
  input  logic [15:0]           color,
  input  logic [7:0]            data_byte,
  input  logic                  rst,
  input  fbrle_pkg::fbrle_cmd_t cmd,
  output fbrle_pkg::fbrle_sts_t sts,
  output logic [15:0]           pixel_value
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(SCREEN_WIDTH + 1);
  localparam int RW = $clog2(SCREEN_HEIGHT + 1);
  localparam logic [CW-1:0] SW_C = CW'(SCREEN_WIDTH);
  localparam logic [RW-1:0] SH_R = RW'(SCREEN_HEIGHT);

  logic [15:0] mem [DEPTH];

  logic [2:0]  kind_q;
  logic signed [10:0] x_q, y_q;
  logic [9:0]  w_q, h_q;
  logic [15:0] color_q;
  logic [7:0]  byte_q;

  // rectangle walker
  logic [CW-1:0] xmin, xmax, cx;
  logic [RW-1:0] ymax, cy;
  logic [AW-1:0] waddr_row;

  // glyph state
  logic signed [10:0] origin_col, origin_row;
  logic [7:0]  glyph_span, cursor_col;
  logic [15:0] cursor_row;
  logic [5:0]  tint_red, tint_green, tint_blue;
  logic        awaiting_count;
  logic [5:0]  pending_gray;
  logic [7:0]  run_left;
  logic [15:0] shade_q;

  logic        we;
  logic [AW-1:0] waddr;
  logic [15:0] wdata;
  logic [AW-1:0] raddr;
  logic [15:0] rdata;
  logic        rd_ok, rd_ok_q;

  logic signed [12:0] xs, ys, xe, ye;
  logic [CW-1:0] xlo;
  logic [RW-1:0] ylo;
  logic signed [17:0] tx, ty;
  logic        gon;
  logic [AW-1:0] gaddr;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q  <= kind;
      x_q     <= x_pos;
      y_q     <= y_pos;
      w_q     <= width_px;
      h_q     <= height_px;
      color_q <= color;
      byte_q  <= data_byte;
    end
  end

  // clipped bounds; a start past the edge clamps to it and leaves the range empty
  always_comb begin
    xs = (kind_q == fbrle_pkg::KIND_CLEAR) ? 13'sd0 : 13'(x_q);
    ys = (kind_q == fbrle_pkg::KIND_CLEAR) ? 13'sd0 : 13'(y_q);
    xe = (kind_q == fbrle_pkg::KIND_CLEAR) ? 13'(SCREEN_WIDTH)
                                           : 13'(x_q) + $signed({3'b0, w_q});
    ye = (kind_q == fbrle_pkg::KIND_CLEAR) ? 13'(SCREEN_HEIGHT)
                                           : 13'(y_q) + $signed({3'b0, h_q});
    xlo = (xs > 0) ? ((xs < 13'(SCREEN_WIDTH)) ? CW'(xs) : SW_C) : '0;
    ylo = (ys > 0) ? ((ys < 13'(SCREEN_HEIGHT)) ? RW'(ys) : SH_R) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rect_init) begin
      xmin <= xlo;
      cx   <= xlo;
      cy   <= ylo;
      xmax <= (xe < 13'(SCREEN_WIDTH)) ? ((xe > 0) ? CW'(xe) : '0) : SW_C;
      ymax <= (ye < 13'(SCREEN_HEIGHT)) ? ((ye > 0) ? RW'(ye) : '0) : SH_R;
      waddr_row <= AW'(ylo) * AW'(SCREEN_WIDTH);
    end else if (cmd.rect_step) begin
      if (cx + 1'b1 == xmax) begin
        cx <= xmin;
        cy <= cy + 1'b1;
        waddr_row <= waddr_row + AW'(SCREEN_WIDTH);
      end else begin
        cx <= cx + 1'b1;
      end
    end
  end

  logic [CW-1:0] xmin_c;
  assign xmin_c = cx;
  assign sts.rect_empty = (xmin >= xmax) || (cy >= ymax);
  assign sts.rect_last  = (cx + 1'b1 == xmax) && (cy + 1'b1 == ymax);

  // glyph
  assign tx = 18'(origin_col) + $signed({10'b0, cursor_col});
  assign ty = 18'(origin_row) + $signed({2'b0, cursor_row});
  assign gon = (tx >= 0) && (ty >= 0) && (tx < 18'(SCREEN_WIDTH)) && (ty < 18'(SCREEN_HEIGHT));
  assign gaddr = AW'(tx[10:0]) + AW'(ty[10:0]) * AW'(SCREEN_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col <= '0; origin_row <= '0; glyph_span <= '0;
      cursor_col <= '0; cursor_row <= '0;
      tint_red <= '0; tint_green <= '0; tint_blue <= '0;
      awaiting_count <= 1'b0; pending_gray <= '0;
    end else if (cmd.gly_start) begin
      origin_col <= x_q;
      origin_row <= y_q;
      glyph_span <= w_q[7:0];
      cursor_col <= '0;
      cursor_row <= '0;
      tint_red   <= color_q[7:2] & fbrle_pkg::TINT_MASK;
      tint_blue  <= color_q[12:7] & fbrle_pkg::TINT_MASK;
      tint_green <= {color_q[2:0] & fbrle_pkg::GREEN_LOW, color_q[15:13]};
      awaiting_count <= 1'b0;
      pending_gray <= '0;
    end else if (cmd.gly_latch) begin
      pending_gray <= byte_q[5:0] & fbrle_pkg::GRAY_MASK;
      awaiting_count <= 1'b1;
    end else if (cmd.gly_run) begin
      awaiting_count <= 1'b0;
    end else if (cmd.gly_step) begin
      if (cursor_col + 8'd1 == glyph_span) begin
        cursor_col <= '0;
        cursor_row <= cursor_row + 16'd1;
      end else begin
        cursor_col <= cursor_col + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gly_lit) begin
      shade_q  <= fbrle_pkg::pack_shade(byte_q[5:0], tint_red, tint_green, tint_blue);
      run_left <= 8'd1;
    end else if (cmd.gly_run) begin
      shade_q  <= fbrle_pkg::pack_shade(pending_gray, tint_red, tint_green, tint_blue);
      run_left <= (byte_q == 8'd0) ? 8'd1 : byte_q;
    end else if (cmd.gly_step) begin
      run_left <= run_left - 8'd1;
    end
  end

  assign sts.gly_last = (run_left == 8'd1);
  assign sts.awaiting = awaiting_count;
  assign sts.run_flag = |(byte_q & fbrle_pkg::RUN_FLAG);

  // frame store port
  always_comb begin
    we = 1'b0;
    waddr = waddr_row + AW'(xmin_c);
    wdata = color_q;
    if (cmd.rect_step) begin
      we = 1'b1;
    end else if (cmd.gly_step) begin
      we = gon;
      waddr = gaddr;
      wdata = shade_q;
    end
  end

  assign rd_ok = (x_q >= 0) && (y_q >= 0) && (12'(x_q) < 12'(SCREEN_WIDTH))
              && (12'(y_q) < 12'(SCREEN_HEIGHT));
  assign raddr = AW'(x_q[9:0]) + AW'(y_q[9:0]) * AW'(SCREEN_WIDTH);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_issue) begin
      rdata   <= mem[raddr];
      rd_ok_q <= rd_ok;
    end
    if (cmd.rd_take) pixel_value <= rd_ok_q ? rdata : 16'd0;
  end

endmodule

[hdl/framebuffer_fill_and_rle_glyph_blit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_fill_and_rle_glyph_blit
// Drawing engine: clear, clipped fill, run-length glyph blit, pixel read.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | kind x_pos y_pos width_px height_px color data_byte
//  out     | out_valid / out_ready | pixel_value
//
//  One item at a time. An item is accepted in idle and decoded; a clear or fill
//  passes a setup state, then writes its clipped area one pixel per cycle. A glyph
//  byte latches a run or writes its pixel or run at the same rate; a read is
//  issued, then taken. A read waits in decode while a result is unclaimed.
//  Reset clears control and glyph state; the frame store is not cleared.
module framebuffer_fill_and_rle_glyph_blit #(
  parameter int SCREEN_WIDTH  = fbrle_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = fbrle_pkg::SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic signed [10:0] x_pos,
  input  logic signed [10:0] y_pos,
  input  logic [9:0]         width_px,
  input  logic [9:0]         height_px,
  input  logic [15:0]        color,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        pixel_value
);

  fbrle_pkg::fbrle_cmd_t cmd;
  fbrle_pkg::fbrle_sts_t sts;
  logic out_set;

  fbrle_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .out_valid, .out_ready,
    .sts, .cmd, .out_set
  );

  fbrle_dpath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_dpath (
    .clk, .kind, .x_pos, .y_pos, .width_px, .height_px, .color, .data_byte,
    .rst, .cmd, .sts, .pixel_value
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_set) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[test/framebuffer_fill_and_rle_glyph_blit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_fill_and_rle_glyph_blit_test
// Self-checking bench for the drawing engine. A scoreboard keeps its own copy
// of the frame store and glyph state, predicts every pixel read and compares
// it with the block's output. Directed items cover the clipping extremes,
// glyph run corners and off-screen reads; random glyph streams, fills and
// reads follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module framebuffer_fill_and_rle_glyph_blit_test;

  localparam int PIXELS    = fbrle_pkg::SCREEN_WIDTH * fbrle_pkg::SCREEN_HEIGHT;
  localparam int STALL_CAP = 300000;

  class pixel_scoreboard;
    logic [15:0] frame [PIXELS];
    int org_c, org_r, span, cur_c, cur_r;
    logic [5:0] tr, tg, tb, gray_hold;
    bit awaiting;
    logic [15:0] reads_due [$];
    int errors;

    function logic [15:0] tinted(logic [5:0] gray);
      logic [11:0] r, g, b;
      r = gray * tr;
      g = gray * tg;
      b = gray * tb;
      return {g[8:6], b[11:7], r[11:7], g[11:9]};
    endfunction

    function void plot(logic [5:0] gray);
      int tx, ty;
      tx = org_c + cur_c;
      ty = org_r + cur_r;
      if (tx >= 0 && ty >= 0 && tx < fbrle_pkg::SCREEN_WIDTH && ty < fbrle_pkg::SCREEN_HEIGHT)
        frame[tx + ty * fbrle_pkg::SCREEN_WIDTH] = tinted(gray);
      cur_c = (cur_c + 1) & 8'hff;
      if (cur_c == span) begin
        cur_c = 0;
        cur_r = (cur_r + 1) & 16'hffff;
      end
    endfunction

    function void note_item(logic [2:0] k, logic signed [10:0] x, logic signed [10:0] y,
                            logic [9:0] w, logic [9:0] h, logic [15:0] c, logic [7:0] b);
      int x0, y0, x1, y1, n;
      case (k)
        fbrle_pkg::KIND_CLEAR: begin
          foreach (frame[i]) frame[i] = c;
        end
        fbrle_pkg::KIND_FILL: begin
          x0 = (x > 0) ? int'(x) : 0;
          y0 = (y > 0) ? int'(y) : 0;
          x1 = (int'(x) + int'(w) < fbrle_pkg::SCREEN_WIDTH) ? int'(x) + int'(w)
                                                             : fbrle_pkg::SCREEN_WIDTH;
          y1 = (int'(y) + int'(h) < fbrle_pkg::SCREEN_HEIGHT) ? int'(y) + int'(h)
                                                              : fbrle_pkg::SCREEN_HEIGHT;
          for (int yy = y0; yy < y1; yy++)
            for (int xx = x0; xx < x1; xx++) frame[xx + yy * fbrle_pkg::SCREEN_WIDTH] = c;
        end
        fbrle_pkg::KIND_GSTART: begin
          org_c = x;
          org_r = y;
          span = w[7:0];
          cur_c = 0;
          cur_r = 0;
          tr = c[7:2] & fbrle_pkg::TINT_MASK;
          tb = c[12:7] & fbrle_pkg::TINT_MASK;
          tg = {c[2:0], c[15:13]};
          awaiting = 0;
          gray_hold = 0;
        end
        fbrle_pkg::KIND_GBYTE: begin
          if (awaiting) begin
            n = (b == 0) ? 1 : int'(b);
            repeat (n) plot(gray_hold);
            awaiting = 0;
          end else if ((b & fbrle_pkg::RUN_FLAG) != 8'd0) begin
            gray_hold = b[5:0] & fbrle_pkg::GRAY_MASK;
            awaiting = 1;
          end else begin
            plot(b[5:0] & fbrle_pkg::GRAY_MASK);
          end
        end
        fbrle_pkg::KIND_READ: begin
          if (x >= 0 && y >= 0 && x < fbrle_pkg::SCREEN_WIDTH && y < fbrle_pkg::SCREEN_HEIGHT)
            reads_due.push_back(frame[int'(x) + int'(y) * fbrle_pkg::SCREEN_WIDTH]);
          else
            reads_due.push_back(16'h0000);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_pixel(logic [15:0] v);
      logic [15:0] want;
      if (reads_due.size() == 0) begin
        report($sformatf("unexpected pixel_value %h", v));
      end else begin
        want = reads_due.pop_front();
        if (v !== want) report($sformatf("pixel_value %h, expected %h", v, want));
      end
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] kind;
  logic signed [10:0] x_pos, y_pos;
  logic [9:0] width_px, height_px;
  logic [15:0] color, pixel_value;
  logic [7:0] data_byte;
  bit quiet;
  int idle_cycles;
  int sent;
  pixel_scoreboard sb;

  framebuffer_fill_and_rle_glyph_blit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .x_pos(x_pos), .y_pos(y_pos),
    .width_px(width_px), .height_px(height_px),
    .color(color), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_value(pixel_value)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task send(int k, int x, int y, int w, int h, int c, int b);
    logic [2:0] kk;
    logic signed [10:0] xx, yy;
    logic [9:0] ww, hh;
    logic [15:0] cc;
    logic [7:0] bb;
    kk = k[2:0];
    xx = x[10:0];
    yy = y[10:0];
    ww = w[9:0];
    hh = h[9:0];
    cc = c[15:0];
    bb = b[7:0];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= kk;
    x_pos     <= xx;
    y_pos     <= yy;
    width_px  <= ww;
    height_px <= hh;
    color     <= cc;
    data_byte <= bb;
    do @(posedge clk); while (!in_ready);
    sb.note_item(kk, xx, yy, ww, hh, cc, bb);
    sent++;
  endtask

  function int any11();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  task glyph_stream(int bytes);
    send(fbrle_pkg::KIND_GSTART,
         $urandom_range(0, 3) == 0 ? any11() : $urandom_range(0, 260) - 20,
         $urandom_range(0, 3) == 0 ? any11() : $urandom_range(0, 260) - 20,
         $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(1, 24),
         $urandom, $urandom, $urandom);
    repeat (bytes) begin
      if ($urandom_range(0, 1)) begin
        send(fbrle_pkg::KIND_GBYTE, any11(), any11(), $urandom, $urandom, $urandom,
             $urandom_range(0, 127));
      end else begin
        send(fbrle_pkg::KIND_GBYTE, any11(), any11(), $urandom, $urandom, $urandom,
             int'(fbrle_pkg::RUN_FLAG) | int'($urandom_range(0, 127)));
        send(fbrle_pkg::KIND_GBYTE, any11(), any11(), $urandom, $urandom, $urandom,
             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12));
      end
    end
  endtask

  task read_some(int n);
    repeat (n)
      send(fbrle_pkg::KIND_READ,
           $urandom_range(0, 9) == 0 ? any11() : $urandom_range(0, fbrle_pkg::SCREEN_WIDTH - 1),
           $urandom_range(0, 9) == 0 ? any11() : $urandom_range(0, fbrle_pkg::SCREEN_HEIGHT - 1),
           $urandom, $urandom, $urandom, $urandom);
  endtask

  // result side: random stalls, none once the run goes quiet
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_pixel(pixel_value);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_CAP) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    quiet = 0;
    sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = fbrle_pkg::KIND_CLEAR;
    x_pos = 0;
    y_pos = 0;
    width_px = 0;
    height_px = 0;
    color = 0;
    data_byte = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send(fbrle_pkg::KIND_CLEAR, 0, 0, 0, 0, 'h5a3c, 0);
    send(fbrle_pkg::KIND_FILL, -1024, -1024, 1023, 1023, 'hffff, 'hff);
    send(fbrle_pkg::KIND_FILL, 1023, 1023, 1023, 1023, 'h0000, 0);
    send(fbrle_pkg::KIND_FILL, -3, -2, 6, 5, 'h1234, 0);
    send(fbrle_pkg::KIND_FILL, 236, 237, 20, 20, 'h8001, 0);
    send(fbrle_pkg::KIND_FILL, 50, 50, 0, 9, 'h0f0f, 0);
    send(fbrle_pkg::KIND_FILL, 300, 20, 10, 10, 'h0001, 0);
    send(fbrle_pkg::KIND_FILL, 20, 700, 10, 10, 'h0002, 0);
    send(fbrle_pkg::KIND_GSTART, -2, -1, 4, 0, 'hffff, 0);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'h7f);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'h00);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'hff);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'h00);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'hbf);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'hff);
    send(fbrle_pkg::KIND_GSTART, 230, 235, 256, 0, 'hb6dd, 0);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'h95);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 40);
    send(fbrle_pkg::KIND_GBYTE, 0, 0, 0, 0, 0, 'h40);
    send(fbrle_pkg::KIND_READ, 0, 0, 0, 0, 0, 0);
    send(fbrle_pkg::KIND_READ, 239, 239, 0, 0, 0, 0);
    send(fbrle_pkg::KIND_READ, 240, 0, 0, 0, 0, 0);
    send(fbrle_pkg::KIND_READ, -1, 5, 0, 0, 0, 0);
    send(fbrle_pkg::KIND_READ, 0, -1024, 0, 0, 0, 0);
    send(fbrle_pkg::KIND_READ, 1023, 1023, 0, 0, 0, 0);
    send(fbrle_pkg::KIND_READ, 25, 25, 0, 0, 0, 0);
    read_some(3);
    send(fbrle_pkg::KIND_READ + 1, 0, 0, 0, 0, 0, 0);
    send(7, any11(), any11(), $urandom, $urandom, $urandom, $urandom);

    // random
    while (sent < 1600) begin
      int n;
      if (sent > 1350) quiet = 1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          n = $urandom_range(1, 10);
          glyph_stream(n);
          read_some(4);
        end
        8, 9, 10, 11, 12, 13, 14: begin
          read_some(6);
        end
        15, 16, 17: begin
          send(fbrle_pkg::KIND_FILL, $urandom_range(0, 270) - 20, $urandom_range(0, 270) - 20,
               $urandom_range(0, 20), $urandom_range(0, 20), $urandom, $urandom);
        end
        18: begin
          if ($urandom_range(0, 7) == 0)
            send(fbrle_pkg::KIND_FILL, any11(), any11(), $urandom, $urandom, $urandom,
                 $urandom);
          else
            send(fbrle_pkg::KIND_GBYTE, any11(), any11(), $urandom, $urandom, $urandom,
                 $urandom);
        end
        default: begin
          send($urandom_range(fbrle_pkg::KIND_READ + 1, 7), any11(), any11(),
               $urandom, $urandom, $urandom, $urandom);
        end
      endcase
    end
    send(fbrle_pkg::KIND_CLEAR, any11(), any11(), $urandom, $urandom, $urandom, $urandom);
    read_some(8);
    in_valid <= 1'b0;

    while (sb.reads_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
hdl/fbrle_pkg.sv
hdl/fbrle_ctrl.sv
hdl/fbrle_dpath.sv
hdl/framebuffer_fill_and_rle_glyph_blit.sv
test/framebuffer_fill_and_rle_glyph_blit_test.sv
